### rtl/core/lph_pkg.sv
// Shared constants, types and a helper function of the linear probing hash insert core.
`default_nettype none

package lph_pkg;

  localparam int MaxSlots  = 1024;
  localparam int SlotW     = $clog2(MaxSlots);
  localparam int SizeW     = 11;
  localparam int KeyW      = 31;
  localparam int OutSlotW  = 10;
  // The remainder unit retires two dividend bits per cycle over a padded key.
  localparam int DivBits   = 32;
  localparam int DivSteps  = DivBits / 2;
  localparam int DivStepW  = $clog2(DivSteps);

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [SlotW-1:0] home;
  } lph_req_t;

  // Size zero acts as one slot; sizes above the table saturate.
  function automatic logic [SizeW-1:0] lph_eff_size(input logic [SizeW-1:0] size);
    logic [SizeW-1:0] res;
    res = size;
    if (size == '0) begin
      res = SizeW'(1);
    end else if (size > SizeW'(MaxSlots)) begin
      res = SizeW'(MaxSlots);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/linear_probe_hash_insert_core.sv
// Top level of the linear probing hash insert core: configuration register and block wiring.
// A request is accepted by the front end, reduced to its home slot by the remainder unit,
// queued, then walked by the probe engine, which reads and checks one slot per probe.
// The front end takes no new key until the current home slot is queued, and the probe
// engine takes no new request until its walk is done and the previous result has left.
// Reset: table size returns to 1024, then a clearing pass over all 1024 slots empties the
// slot memory; no request is accepted during the pass, configuration writes are.
`default_nettype none

module linear_probe_hash_insert_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [lph_pkg::SizeW-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [lph_pkg::KeyW-1:0]     key_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [lph_pkg::OutSlotW-1:0]      slot_o,
  output logic                              was_present_o,
  output logic                              table_full_o
);
  import lph_pkg::*;

  logic [SizeW-1:0] table_size_q;
  logic [SizeW-1:0] eff_size;
  logic             front_ready;
  logic             clearing;
  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  lph_req_t         push_req, pop_req;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= SizeW'(MaxSlots);
    end else if (cfg_valid_i) begin
      table_size_q <= cfg_data_i;
    end
  end

  assign eff_size   = lph_eff_size(table_size_q);
  assign in_ready_o = front_ready & ~clearing;

  lph_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_i      (eff_size),
    .in_valid_i  (in_valid_i & ~clearing),
    .in_ready_o  (front_ready),
    .key_i       (key_i),
    .req_valid_o (push_valid),
    .req_ready_i (push_ready),
    .req_o       (push_req)
  );

  lph_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_i       (push_req),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_o        (pop_req)
  );

  lph_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .size_i        (eff_size),
    .req_valid_i   (pop_valid),
    .req_ready_o   (pop_ready),
    .req_i         (pop_req),
    .clearing_o    (clearing),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .slot_o        (slot_o),
    .was_present_o (was_present_o),
    .table_full_o  (table_full_o)
  );

endmodule

`default_nettype wire

### rtl/core/lph_front.sv
// Front end: accepts keys and computes the home slot with an iterative remainder unit.
`default_nettype none

module lph_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [lph_pkg::SizeW-1:0] size_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [lph_pkg::KeyW-1:0] key_i,
  output logic                          req_valid_o,
  input  wire logic                     req_ready_i,
  output lph_pkg::lph_req_t             req_o
);
  import lph_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StPush = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [DivStepW-1:0] step_q, step_d;
  logic [DivBits-1:0]  dvd_q, dvd_d;
  logic [SizeW-1:0]    rem_q, rem_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [DivBits-1:0]  dvd_nxt;
  logic [SizeW-1:0]    rem_nxt;

  // Two restoring steps per cycle; the remainder stays below the size.
  always_comb begin
    logic [SizeW:0] part;
    logic [SizeW:0] dvs;
    dvd_nxt = dvd_q;
    rem_nxt = rem_q;
    dvs     = {1'b0, size_i};
    for (int i = 0; i < 2; i++) begin
      part = {rem_nxt, dvd_nxt[DivBits-1]};
      if (part >= dvs) begin
        part = part - dvs;
      end
      rem_nxt = part[SizeW-1:0];
      dvd_nxt = {dvd_nxt[DivBits-2:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    key_d   = key_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          key_d   = key_i;
          dvd_d   = DivBits'(key_i);
          rem_d   = '0;
          step_d  = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        dvd_d  = dvd_nxt;
        rem_d  = rem_nxt;
        step_d = step_q + DivStepW'(1);
        if (step_q == DivStepW'(DivSteps - 1)) begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (req_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    key_q <= key_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign req_valid_o = (state_q == StPush);
  assign req_o.key   = key_q;
  assign req_o.home  = rem_q[SlotW-1:0];

endmodule

`default_nettype wire

### rtl/core/lph_fifo.sv
// Two-entry request queue between the front end and the probe engine.
`default_nettype none

module lph_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire lph_pkg::lph_req_t push_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output lph_pkg::lph_req_t     pop_o
);
  import lph_pkg::*;

  lph_req_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_o        = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lph_back.sv
// Probe engine: walks the slot memory from the home slot and inserts or locates the key.
`default_nettype none

module lph_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [lph_pkg::SizeW-1:0]  size_i,
  input  wire logic                       req_valid_i,
  output logic                            req_ready_o,
  input  wire lph_pkg::lph_req_t          req_i,
  output logic                            clearing_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [lph_pkg::OutSlotW-1:0]    slot_o,
  output logic                            was_present_o,
  output logic                            table_full_o
);
  import lph_pkg::*;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StRead  = 2'd2;
  localparam logic [1:0] StCheck = 2'd3;

  // Each word holds the occupied mark in its top bit above the stored key.
  logic [KeyW:0] mem [MaxSlots];
  logic [KeyW:0] rdata_q;

  logic [1:0]       state_q, state_d;
  logic [SlotW-1:0] clr_q, clr_d;
  logic [SlotW-1:0] pos_q, pos_d;
  logic [SizeW-1:0] cnt_q, cnt_d;
  logic [KeyW-1:0]  key_q, key_d;

  logic                out_valid_q, out_valid_d;
  logic [OutSlotW-1:0] slot_q, slot_d;
  logic                present_q, present_d;
  logic                full_q, full_d;

  logic             mem_we;
  logic [SlotW-1:0] mem_waddr;
  logic [KeyW:0]    mem_wdata;
  logic [SlotW:0]   pos_inc;
  logic [SizeW-1:0] cnt_inc;

  assign pos_inc = {1'b0, pos_q} + (SlotW + 1)'(1);
  assign cnt_inc = cnt_q + SizeW'(1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    slot_d      = slot_q;
    present_d   = present_q;
    full_d      = full_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = {1'b1, key_q};
    req_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + SlotW'(1);
        if (clr_q == SlotW'(MaxSlots - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        // A new request starts only once the previous result has left.
        req_ready_o = ~out_valid_q;
        if (req_valid_i && !out_valid_q) begin
          key_d   = req_i.key;
          pos_d   = req_i.home;
          cnt_d   = '0;
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StCheck;
      end
      StCheck: begin
        if (!rdata_q[KeyW]) begin
          mem_we      = 1'b1;
          out_valid_d = 1'b1;
          slot_d      = OutSlotW'(pos_q);
          present_d   = 1'b0;
          full_d      = 1'b0;
          state_d     = StIdle;
        end else if (rdata_q[KeyW-1:0] == key_q) begin
          out_valid_d = 1'b1;
          slot_d      = OutSlotW'(pos_q);
          present_d   = 1'b1;
          full_d      = 1'b0;
          state_d     = StIdle;
        end else if (cnt_inc == size_i) begin
          // Every slot in use was probed once without a match or a hole.
          out_valid_d = 1'b1;
          slot_d      = '0;
          present_d   = 1'b0;
          full_d      = 1'b1;
          state_d     = StIdle;
        end else begin
          cnt_d   = cnt_inc;
          pos_d   = (SizeW'(pos_inc) >= size_i) ? '0 : pos_inc[SlotW-1:0];
          state_d = StRead;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    cnt_q     <= cnt_d;
    key_q     <= key_d;
    slot_q    <= slot_d;
    present_q <= present_d;
    full_q    <= full_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[pos_q];
  end

  assign clearing_o    = (state_q == StClear);
  assign out_valid_o   = out_valid_q;
  assign slot_o        = slot_q;
  assign was_present_o = present_q;
  assign table_full_o  = full_q;

endmodule

`default_nettype wire
